### hw/rtl/b64d_pkg.sv
// Shared types, constants and decode functions of the base64 stream decoder.
package b64d_pkg;

  // Fixed character codes.
  localparam logic [7:0] CharPad   = 8'h3d;  // '='
  localparam logic [7:0] CharLowB  = 8'h62;  // 'b'
  localparam logic [3:0] MarkerLen = 4'd7;   // length of "base64,"

  // Default depth of the queue between front and back.
  localparam int QueueDepthDef = 4;

  // One request's worth of results, handed from front to back.
  typedef struct packed {
    logic [1:0]      n_res;    // number of results, 1 to 3
    logic            no_byte;  // results carry no byte
    logic            discard;  // marker result
    logic            str_end;  // caused by the last character
    logic [2:0][7:0] bytes;    // decoded bytes, first in element 0
  } bundle_t;

  // Front state made visible for checks at the top level.
  typedef struct packed {
    logic [1:0] pending;
    logic       stopped;
    logic       marker_seen;
  } front_status_t;

  // Sextet value of a character; bit 6 set means not a base64 character.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = 7'd62;
    end else if (c == 8'h2f) begin
      r = 7'd63;
    end
    return r;
  endfunction

  // Character expected at each position of the marker text.
  function automatic logic [7:0] marker_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h62;  // b
      3'd1:    r = 8'h61;  // a
      3'd2:    r = 8'h73;  // s
      3'd3:    r = 8'h65;  // e
      3'd4:    r = 8'h36;  // 6
      3'd5:    r = 8'h34;  // 4
      3'd6:    r = 8'h2c;  // ,
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] byte0(input logic [5:0] s0, input logic [5:0] s1);
    return {s0, s1[5:4]};
  endfunction

  function automatic logic [7:0] byte1(input logic [5:0] s1, input logic [5:0] s2);
    return {s1[3:0], s2[5:2]};
  endfunction

  function automatic logic [7:0] byte2(input logic [5:0] s2, input logic [5:0] s3);
    return {s2[1:0], s3};
  endfunction

endpackage

### hw/rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front end, bundle queue and back end.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+------------------------------------------------
//   input   | in_valid, in_stall  | char_code, last_char
//   output  | out_valid, out_stall| data_byte, byte_valid, discard_earlier,
//           |                     | string_end, last_of_run
//
// One character is accepted per cycle while in_stall is low; results pass through the queue
// and the output register. The back end delivers one result per cycle unless out_stall holds
// it, so a completed group's three results hold it while the QUEUE_DEPTH queue absorbs input.
// Reset is synchronous and empties the queue, the output register and the string state.
// in_stall rises only when the queue is full; out_stall holds the current result in place.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       discard_earlier,
  output logic       string_end,
  output logic       last_of_run
);

  logic          accept;
  logic          push;
  bundle_t       bundle;
  front_status_t status;
  bundle_t       head;
  logic          head_valid;
  logic          pop;
  logic          full;

  assign in_stall = full;
  assign accept   = in_valid && ~in_stall;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .last_char (last_char),
    .push      (push),
    .bundle    (bundle),
    .status    (status)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (bundle),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  b64d_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .discard_earlier (discard_earlier),
    .string_end      (string_end),
    .last_of_run     (last_of_run)
  );

  // The end-of-string result always closes its request's run.
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> last_of_run)
    else $error("string_end without last_of_run");

  // A marker result never carries a byte.
  a_discard_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && discard_earlier |-> !byte_valid && data_byte == 8'h00)
    else $error("marker result carries a byte");

  // The last character leaves the front end in its start state.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_char |=> status.pending == 2'd0 && !status.stopped
                            && !status.marker_seen)
    else $error("string state not cleared after last character");

  // Every accepted last character produces at least one queued result.
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && last_char |-> push)
    else $error("last character produced no result");

endmodule

### hw/rtl/b64d_front.sv
// Front end: accepts characters, tracks group and marker state, builds result bundles.
module b64d_front
  import b64d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_code,
  input  logic          last_char,
  output logic          push,
  output bundle_t       bundle,
  output front_status_t status
);

  logic [2:0][5:0] store;
  logic [1:0]      pending;
  logic            stopped;
  logic [2:0]      progress;
  logic            marker_seen;

  logic [6:0]      sext;
  logic            sx_ok;
  logic            is_pad;
  logic [3:0]      prog_raw;
  logic            hit;
  logic            decode_on;
  logic            do_pad;
  logic            do_sx;
  logic            full;
  logic [3:0][5:0] grp;
  logic [1:0]      np;
  logic            stopped_after;
  logic            flush;
  logic [1:0]      nbytes;

  // Classify the character and advance the marker matcher.
  always_comb begin
    sext   = sextet_of(char_code);
    sx_ok  = ~sext[6];
    is_pad = (char_code == CharPad);
    if (char_code == marker_char(progress)) begin
      prog_raw = {1'b0, progress} + 4'd1;
    end else begin
      prog_raw = (char_code == CharLowB) ? 4'd1 : 4'd0;
    end
    hit = ~marker_seen && (prog_raw == MarkerLen);
  end

  // Decode step: the group as it stands after this character, and what is flushed.
  always_comb begin
    decode_on = ~hit && ~stopped;
    do_pad    = decode_on && is_pad;
    do_sx     = decode_on && ~is_pad && sx_ok;
    full      = do_sx && (pending == 2'd3);
    for (int i = 0; i < 3; i++) begin
      grp[i] = (do_sx && (pending == 2'(i))) ? sext[5:0] : store[i];
    end
    grp[3] = sext[5:0];
    if (hit || full) begin
      np = 2'd0;
    end else if (do_sx) begin
      np = pending + 2'd1;
    end else begin
      np = pending;
    end
    stopped_after = hit ? 1'b0 : (do_pad ? 1'b1 : stopped);
    flush         = do_pad || (last_char && ~stopped_after);
    if (full) begin
      nbytes = 2'd3;
    end else if (flush && np >= 2'd2) begin
      nbytes = np - 2'd1;
    end else begin
      nbytes = 2'd0;
    end
  end

  // Assemble the bundle for the back end.
  always_comb begin
    bundle.bytes[0] = byte0(grp[0], grp[1]);
    bundle.bytes[1] = byte1(grp[1], grp[2]);
    bundle.bytes[2] = byte2(grp[2], grp[3]);
    bundle.discard  = hit;
    bundle.no_byte  = hit || (nbytes == 2'd0);
    bundle.str_end  = last_char;
    if (hit || (last_char && nbytes == 2'd0)) begin
      bundle.n_res = 2'd1;
    end else begin
      bundle.n_res = nbytes;
    end
    push = accept && (bundle.n_res != 2'd0);
  end

  // Per-string state; the last character returns everything to its start.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= 2'd0;
      stopped     <= 1'b0;
      progress    <= 3'd0;
      marker_seen <= 1'b0;
    end else if (accept) begin
      if (last_char) begin
        pending     <= 2'd0;
        stopped     <= 1'b0;
        progress    <= 3'd0;
        marker_seen <= 1'b0;
      end else begin
        pending <= flush ? 2'd0 : np;
        stopped <= stopped_after;
        if (~marker_seen) begin
          progress    <= hit ? 3'd0 : prog_raw[2:0];
          marker_seen <= hit;
        end
      end
    end
  end

  // Sextet store holds payload only; pending says which entries count.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        store[i] <= grp[i];
      end
    end
  end

  assign status.pending     = pending;
  assign status.stopped     = stopped;
  assign status.marker_seen = marker_seen;

endmodule

### hw/rtl/b64d_queue.sv
// Short register queue of result bundles between front and back.
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    head_valid,
  output logic    full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  bundle_t         slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CntFull);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && ~pop) begin
        count <= count + 1'b1;
      end else if (pop && ~push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/b64d_back.sv
// Back end: splits each bundle into single results behind an output register.
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       discard_earlier,
  output logic       string_end,
  output logic       last_of_run
);

  logic [1:0] idx;
  logic       advance;
  logic       load;
  logic       at_last;

  // Load a new result whenever the output register is empty or being taken.
  always_comb begin
    advance = ~out_valid || ~out_stall;
    load    = advance && head_valid;
    at_last = (idx == head.n_res - 2'd1);
    pop     = load && at_last;
  end

  // Output register and position within the current bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      data_byte       <= head.no_byte ? 8'h00 : head.bytes[idx];
      byte_valid      <= ~head.no_byte;
      discard_earlier <= head.discard;
      string_end      <= head.str_end && at_last;
      last_of_run     <= at_last;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the base64 stream decoder: directed table, long hold, then random strings.
module tb_top;
  import b64d_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam int RANDOM_ITEMS   = 45;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CALM_ITEMS     = 20;
  localparam int DIR_ROWS       = 23;
  localparam int TAG_CHARS      = 7;
  localparam int MAX_PRINTS     = 20;
  localparam logic [55:0] TAG_TEXT   = "base64,";
  localparam logic [7:0]  CHAR_COMMA = 8'h2c;

  // One result as it leaves the decoder.
  typedef struct packed {
    logic [7:0] data;
    logic       bval;
    logic       disc;
    logic       send;
    logic       lrun;
  } res_t;

  localparam res_t RES_PREDICT   = '0;
  localparam res_t RES_EMPTY_END = {8'h00, 4'b0011};
  localparam res_t RES_MARKER    = {8'h00, 4'b0101};

  // One row of the directed table; a typed row carries its single expected result.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    logic       typed;
    res_t       want;
  } row_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       discard_earlier;
  logic       string_end;
  logic       last_of_run;

  // Predictor state for the string in progress.
  logic [5:0] grp_sx [3];
  int         grp_cnt   = 0;
  logic       pad_stop  = 1'b0;
  logic [2:0] tag_pos   = 3'd0;
  logic       tag_found = 1'b0;
  res_t       step_res [3];
  int         step_n;

  res_t       exp_q [$];
  logic [7:0] str_buf [$];
  row_t       dir_tab [DIR_ROWS];

  logic hold_req = 1'b0;
  logic no_gap   = 1'b0;
  logic calm     = 1'b0;
  int   err_cnt  = 0;
  int   quiet_cycles = 0;
  int   n_chars = 0, n_live = 0, n_strings = 0;
  int   n_results = 0, n_bytes = 0, n_markers = 0, n_in_held = 0;

  base64_stream_decoder u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_code       (char_code),
    .last_char       (last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .discard_earlier (discard_earlier),
    .string_end      (string_end),
    .last_of_run     (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed table: extremes, pads, dropped codes, the marker after a stop, empty string ends.
  initial begin
    dir_tab = '{
      {CharPad,    1'b1, 1'b1, RES_EMPTY_END},  // lone pad ends an empty string
      {8'h54,      1'b0, 1'b0, RES_PREDICT},    // T
      {8'h57,      1'b0, 1'b0, RES_PREDICT},    // W
      {8'h46,      1'b0, 1'b0, RES_PREDICT},    // F
      {8'h75,      1'b0, 1'b0, RES_PREDICT},    // u completes a group
      {8'hff,      1'b0, 1'b0, RES_PREDICT},    // high codes are dropped
      {8'h80,      1'b0, 1'b0, RES_PREDICT},
      {8'h2f,      1'b0, 1'b0, RES_PREDICT},    // /
      {8'h2f,      1'b0, 1'b0, RES_PREDICT},
      {8'h2f,      1'b0, 1'b0, RES_PREDICT},
      {8'h2b,      1'b0, 1'b0, RES_PREDICT},    // +
      {8'h41,      1'b0, 1'b0, RES_PREDICT},    // A, a single sextet
      {CharPad,    1'b0, 1'b0, RES_PREDICT},    // pad with one sextet gives nothing
      {8'h62,      1'b0, 1'b0, RES_PREDICT},    // marker text after the stop
      {8'h61,      1'b0, 1'b0, RES_PREDICT},
      {8'h73,      1'b0, 1'b0, RES_PREDICT},
      {8'h65,      1'b0, 1'b0, RES_PREDICT},
      {8'h36,      1'b0, 1'b0, RES_PREDICT},
      {8'h34,      1'b0, 1'b0, RES_PREDICT},
      {CHAR_COMMA, 1'b0, 1'b1, RES_MARKER},     // marker completes and clears the stop
      {8'h51,      1'b0, 1'b0, RES_PREDICT},    // Q
      {8'h51,      1'b1, 1'b0, RES_PREDICT},    // Q, flushed at the end
      {8'h00,      1'b1, 1'b1, RES_EMPTY_END}   // string of a single dropped code
    };
  end

  function automatic logic [7:0] tag_char(input int idx);
    return TAG_TEXT[8 * (TAG_CHARS - 1 - idx) +: 8];
  endfunction

  // Sextet of a character; bit 6 marks a character outside the alphabet.
  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return {1'b0, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7a) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (c == 8'h2b) return 7'd62;
    if (c == 8'h2f) return 7'd63;
    return 7'h40;
  endfunction

  function automatic logic [7:0] b64_char(input int idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    return (idx == 62) ? 8'h2b : 8'h2f;
  endfunction

  // Appends one expected result to the tail of the expectation queue.
  task automatic expect_res(input res_t r);
    exp_q.insert(exp_q.size(), r);
  endtask

  // Appends one character to the string being built.
  task automatic add_char(input logic [7:0] c);
    str_buf.insert(str_buf.size(), c);
  endtask

  task automatic push_res(input logic [7:0] d, input logic bv, input logic ds);
    step_res[step_n] = {bv ? d : 8'h00, bv, ds, 2'b00};
    step_n++;
  endtask

  // A partial group gives one byte for two sextets and two for three.
  task automatic flush_group();
    if (grp_cnt >= 2) push_res({grp_sx[0], grp_sx[1][5:4]}, 1'b1, 1'b0);
    if (grp_cnt >= 3) push_res({grp_sx[1][3:0], grp_sx[2][5:2]}, 1'b1, 1'b0);
    grp_cnt = 0;
  endtask

  task automatic clear_string();
    grp_sx    = '{6'd0, 6'd0, 6'd0};
    grp_cnt   = 0;
    pad_stop  = 1'b0;
    tag_pos   = 3'd0;
    tag_found = 1'b0;
  endtask

  // Works out the results of one accepted request into step_res.
  task automatic predict_request(input logic [7:0] c, input logic is_last);
    int         p;
    logic       hit;
    logic [6:0] v;
    hit    = 1'b0;
    step_n = 0;
    // Scan for the marker text, only until its first occurrence.
    if (!tag_found) begin
      p = tag_pos;
      if (c == tag_char(p)) p++;
      else p = (c == CharLowB) ? 1 : 0;
      if (p == TAG_CHARS) begin
        hit       = 1'b1;
        tag_found = 1'b1;
        p         = 0;
      end
      tag_pos = 3'(p);
    end
    // Decode, unless the marker took this character or a pad has stopped the string.
    if (hit) begin
      grp_cnt  = 0;
      pad_stop = 1'b0;
      grp_sx   = '{6'd0, 6'd0, 6'd0};
      push_res(8'h00, 1'b0, 1'b1);
    end else if (!pad_stop) begin
      if (c == CharPad) begin
        flush_group();
        pad_stop = 1'b1;
      end else begin
        v = char_value(c);
        if (!v[6]) begin
          if (grp_cnt < 3) begin
            grp_sx[grp_cnt] = v[5:0];
            grp_cnt++;
          end else begin
            push_res({grp_sx[0], grp_sx[1][5:4]}, 1'b1, 1'b0);
            push_res({grp_sx[1][3:0], grp_sx[2][5:2]}, 1'b1, 1'b0);
            push_res({grp_sx[2][1:0], v[5:0]}, 1'b1, 1'b0);
            grp_cnt = 0;
          end
        end
      end
    end
    // The final character flushes what is left and always yields a result.
    if (is_last) begin
      if (!pad_stop) flush_group();
      if (step_n == 0) push_res(8'h00, 1'b0, 1'b0);
      step_res[step_n - 1].send = 1'b1;
      clear_string();
    end
    if (step_n > 0) step_res[step_n - 1].lrun = 1'b1;
  endtask

  // Offers one request, waits for it to be taken and queues what it should produce.
  task automatic send_request(input logic [7:0] c, input logic is_last, input logic typed,
                              input res_t want);
    logic [6:0] cv;
    if (!calm && !no_gap && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(c, is_last);
    if (typed) expect_res(want);
    else for (int i = 0; i < step_n; i++) expect_res(step_res[i]);
    n_chars++;
    if (is_last) n_strings++;
    cv = char_value(c);
    if (!cv[6] || c == CharPad || c == CHAR_COMMA || is_last) n_live++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_buf.size(); i++)
      send_request(str_buf[i], i == str_buf.size() - 1, 1'b0, RES_PREDICT);
  endtask

  task automatic push_tag(input int upto);
    for (int i = 0; i < upto; i++) add_char(tag_char(i));
  endtask

  // Builds one random string: mostly well-formed text, some broken text, some noise.
  task automatic build_string();
    int kind, n, tail;
    str_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(0, 4)) add_char(8'(8'h20 + $urandom_range(0, 94)));
        push_tag(TAG_CHARS);
      end
      n = $urandom_range(0, 4);
      repeat (4 * n) begin
        if ($urandom_range(0, 9) == 0) add_char(8'(8'h80 + $urandom_range(0, 127)));
        add_char(b64_char($urandom_range(0, 63)));
      end
      tail = $urandom_range(0, 3);
      repeat (tail) add_char(b64_char($urandom_range(0, 63)));
      if (tail >= 2 && $urandom_range(0, 1) == 1) repeat (4 - tail) add_char(CharPad);
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) add_char(b64_char($urandom_range(0, 63)));
      if ($urandom_range(0, 7) == 0) push_tag(TAG_CHARS);
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 12)) begin
        n = $urandom_range(0, 19);
        if (n < 8) add_char(b64_char($urandom_range(0, 63)));
        else if (n < 11) add_char(CharPad);
        else if (n < 15) push_tag($urandom_range(1, TAG_CHARS));
        else add_char(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
    end
    if (str_buf.size() == 0) add_char(b64_char($urandom_range(0, 63)));
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Result check against the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {data_byte, byte_valid, discard_earlier, string_end, last_of_run};
      n_results++;
      if (byte_valid) n_bytes++;
      if (discard_earlier) n_markers++;
      if (exp_q.size() == 0) begin
        report_mismatch("result with nothing expected", got.data, 8'h00);
      end else begin
        want = exp_q.pop_front();
        if (got.data != want.data) report_mismatch("data_byte", got.data, want.data);
        if (got.bval != want.bval) report_mismatch("byte_valid", got.bval, want.bval);
        if (got.disc != want.disc) report_mismatch("discard_earlier", got.disc, want.disc);
        if (got.send != want.send) report_mismatch("string_end", got.send, want.send);
        if (got.lrun != want.lrun) report_mismatch("last_of_run", got.lrun, want.lrun);
      end
    end
  end

  // Receiver: short random stalls, and one long hold when asked for.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (rst || stall_left == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left--;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or a result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && in_valid && in_stall) n_in_held <= n_in_held + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL base64_stream_decoder");
      $finish;
    end
  end

  // Main sequence.
  initial begin : stimulus
    int live_goal;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_tab[i].ch, dir_tab[i].is_last, dir_tab[i].typed, dir_tab[i].want);

    // Sender pauses until every result has come out.
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);

    // Long receiver hold while a long string is offered back to back.
    hold_req = 1'b1;
    no_gap   = 1'b1;
    str_buf.delete();
    repeat (32) add_char(b64_char($urandom_range(0, 63)));
    send_string();
    no_gap = 1'b0;

    // Random strings; the final stretch runs without idling on either side.
    live_goal = n_live + RANDOM_ITEMS;
    while (n_live < live_goal) begin
      if (n_live + CALM_ITEMS >= live_goal) calm = 1'b1;
      build_string();
      send_string();
    end

    // Drain, then keep checking for any stray result.
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d strings of %0d characters; checked %0d results, %0d bytes, %0d markers.",
             n_strings, n_chars, n_results, n_bytes, n_markers);
    $display("Input was held off for %0d cycles by a full decoder.", n_in_held);
    if (err_cnt == 0) begin
      $display("PASS base64_stream_decoder");
    end else begin
      $display("FAIL base64_stream_decoder");
    end
    $finish;
  end

endmodule
